// ===== hdl/mpsch_pkg.sv =====
package mpsch_pkg;

  localparam int unsigned TimeW = 12;
  localparam int unsigned WaitW = 16;
  localparam int unsigned ProdW = TimeW + WaitW;
  localparam logic [WaitW-1:0] WaitMax = '1;

  localparam logic [2:0] StPushed   = 3'd0;
  localparam logic [2:0] StFull     = 3'd1;
  localparam logic [2:0] StEmpty    = 3'd2;
  localparam logic [2:0] StComplete = 3'd3;
  localparam logic [2:0] StSlice    = 3'd4;

  localparam logic ReqPush     = 1'b0;
  localparam logic ReqDispatch = 1'b1;

  localparam logic [2:0] PolFifo     = 3'd0;
  localparam logic [2:0] PolSjf      = 3'd1;
  localparam logic [2:0] PolPrio     = 3'd2;
  localparam logic [2:0] PolHrrn     = 3'd3;
  localparam logic [2:0] PolRr       = 3'd4;
  localparam logic [2:0] PolPrioPre  = 3'd5;
  localparam logic [2:0] PolPrioRr   = 3'd6;
  localparam logic [2:0] PolSrt      = 3'd7;

  localparam logic RegPolicy  = 1'b0;
  localparam logic RegQuantum = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [7:0]       proc_id;
    logic [3:0]       priority_req;
    logic [TimeW-1:0] burst_time;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       run_id;
    logic [TimeW-1:0] run_time;
    logic [TimeW-1:0] time_left;
    logic [3:0]       queue_count;
  } rsp_t;

  typedef struct packed {
    logic [7:0]       id;
    logic [3:0]       prio;
    logic [TimeW-1:0] tm;
    logic [WaitW-1:0] wt;
  } entry_t;

  typedef struct packed {
    logic             push;
    logic             remove;
    logic             upd_time;
    logic             inc_wait;
    logic [5:0]       pos;
    entry_t           wdata;
    logic [TimeW-1:0] wtime;
  } store_cmd_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_HINC  = 8'b0000_0010,
    S_SCAN  = 8'b0000_0100,
    S_MULA  = 8'b0000_1000,
    S_MULB  = 8'b0001_0000,
    S_RSCAN = 8'b0010_0000,
    S_EXEC  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

endpackage

// ===== hdl/mpsch_store.sv =====
module mpsch_store import mpsch_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                           clk_i,
  input  store_cmd_t                     cmd_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_idx_i,
  output entry_t                         rd_data_o
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);

  entry_t ent_q [QUEUE_DEPTH];

  logic [IW-1:0] pos;
  assign pos = cmd_i.pos[IW-1:0];
  assign rd_data_o = ent_q[rd_idx_i];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd_i.push && pos == IW'(i)) begin
        ent_q[i] <= cmd_i.wdata;
      end else if (cmd_i.remove && IW'(i) >= pos && i < QUEUE_DEPTH - 1) begin
        ent_q[i] <= ent_q[(i + 1) % QUEUE_DEPTH];
      end else if (cmd_i.upd_time && pos == IW'(i)) begin
        ent_q[i].tm <= cmd_i.wtime;
      end else if (cmd_i.inc_wait && ent_q[i].wt != WaitMax) begin
        ent_q[i].wt <= ent_q[i].wt + 1'b1;
      end
    end
  end

endmodule

// ===== hdl/multi_policy_ready_queue_scheduler_top.sv =====
// Multi-policy ready-queue scheduler.
// Input channel (in_valid_i/in_ready_o, in_data_i) carries push or dispatch
// requests; every accepted transaction yields exactly one result on the output
// channel (out_valid_o/out_ready_i, out_data_o). Policy and quantum are set
// through the APB port (0x0 policy, 0x4 quantum) while the block is idle; the
// user must keep to that, as the block itself does not enforce it. One
// request is worked at a time; in_ready_o is high only in the idle state. A
// push or an empty dispatch goes straight to the done state, FIFO and round
// robin to the execute state; shortest job, priority and SRT scan the queue,
// one entry per cycle through a single read port; priority round robin then
// rescans from the rotation point; HRRN ages all entries, then forms cross
// products on a shared 16x12 multiplier (MULA, MULB); compaction is one shift.
// A finished result sits in the output register; a new request is taken while
// it waits, but its own result stalls until the register frees.
// Reset empties the queue, clears the rotation pointer, sets policy to FIFO
// and quantum to 30. Queue contents are not cleared.
module multi_policy_ready_queue_scheduler_top import mpsch_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [IW-1:0]    rot_q, rot_d;
  logic [2:0]       policy_q;
  logic [TimeW-1:0] quantum_q;
  logic [CW-1:0]    idx_q, idx_d;
  logic [IW-1:0]    best_idx_q, best_idx_d;
  logic [TimeW-1:0] best_time_q, best_time_d;
  logic [3:0]       best_prio_q, best_prio_d;
  logic [WaitW-1:0] best_wait_q, best_wait_d;
  logic [ProdW-1:0] prod_q, prod_d;
  rsp_t             res_q, res_d;
  rsp_t             out_q;
  logic             out_valid_q;

  store_cmd_t       cmd;
  logic [IW-1:0]    rd_idx;
  entry_t           rd;
  logic [WaitW-1:0] mul_a;
  logic [TimeW-1:0] mul_b;
  logic [ProdW-1:0] mul_p;
  logic [IW-1:0]    rot_eff;
  logic             preempt, complete, out_free, cfg_wr;

  mpsch_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd)
  );

  // shared multiplier for HRRN cross products
  assign mul_a = (state_q == S_MULA) ? rd.wt : best_wait_q;
  assign mul_b = (state_q == S_MULA) ? best_time_q : rd.tm;
  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  always_comb begin
    unique case (state_q)
      S_SCAN, S_MULA, S_MULB, S_RSCAN: rd_idx = idx_q[IW-1:0];
      S_EXEC:                          rd_idx = best_idx_q;
      default:                         rd_idx = '0;
    endcase
  end

  assign rot_eff  = (CW'(rot_q) >= count_q) ? '0 : rot_q;
  assign preempt  = (policy_q == PolRr) || (policy_q == PolPrioPre) ||
                    (policy_q == PolPrioRr) || (policy_q == PolSrt);
  assign complete = !preempt || (rd.tm <= quantum_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rot_d       = rot_q;
    idx_d       = idx_q;
    best_idx_d  = best_idx_q;
    best_time_d = best_time_q;
    best_prio_d = best_prio_q;
    best_wait_d = best_wait_q;
    prod_d      = prod_q;
    res_d       = res_q;
    cmd         = '0;
    cmd.wdata   = entry_t'{id: in_data_i.proc_id, prio: in_data_i.priority_req,
                           tm: in_data_i.burst_time, wt: '0};
    cmd.pos     = 6'(count_q[IW-1:0]);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d       = '0;
          state_d     = S_DONE;
          idx_d       = CW'(1);
          best_idx_d  = '0;
          best_time_d = rd.tm;
          best_prio_d = rd.prio;
          if (in_data_i.req_type == ReqPush) begin
            if (count_q >= CW'(QUEUE_DEPTH)) begin
              res_d.status = StFull;
            end else begin
              cmd.push     = 1'b1;
              count_d      = count_q + 1'b1;
              res_d.status = StPushed;
            end
          end else if (count_q == '0) begin
            res_d.status = StEmpty;
          end else begin
            unique case (policy_q)
              PolFifo: state_d = S_EXEC;
              PolRr: begin
                rot_d      = rot_eff;
                best_idx_d = rot_eff;
                state_d    = S_EXEC;
              end
              PolPrioRr: begin
                rot_d   = rot_eff;
                state_d = S_SCAN;
              end
              PolHrrn: state_d = S_HINC;
              default: state_d = S_SCAN;
            endcase
          end
        end
      end
      S_HINC: begin
        cmd.inc_wait = 1'b1;
        best_wait_d  = (rd.wt == WaitMax) ? rd.wt : rd.wt + 1'b1;
        state_d      = S_MULA;
      end
      S_SCAN: begin
        if (idx_q >= count_q) begin
          if (policy_q == PolPrioRr) begin
            idx_d   = CW'(rot_q);
            state_d = S_RSCAN;
          end else begin
            state_d = S_EXEC;
          end
        end else begin
          if ((policy_q == PolSjf || policy_q == PolSrt) ? (rd.tm < best_time_q)
                                                         : (rd.prio > best_prio_q)) begin
            best_idx_d  = idx_q[IW-1:0];
            best_time_d = rd.tm;
            best_prio_d = rd.prio;
          end
          idx_d = idx_q + 1'b1;
        end
      end
      S_RSCAN: begin
        // first top-priority entry at or after the rotation point, else the scan's pick
        if (idx_q >= count_q) begin
          state_d = S_EXEC;
        end else if (rd.prio == best_prio_q) begin
          best_idx_d = idx_q[IW-1:0];
          state_d    = S_EXEC;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_MULA: begin
        if (idx_q >= count_q) begin
          state_d = S_EXEC;
        end else begin
          prod_d  = mul_p;
          state_d = S_MULB;
        end
      end
      S_MULB: begin
        if (prod_q > mul_p) begin
          best_idx_d  = idx_q[IW-1:0];
          best_wait_d = rd.wt;
          best_time_d = rd.tm;
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_MULA;
      end
      S_EXEC: begin
        res_d.run_id = rd.id;
        cmd.pos      = 6'(best_idx_q);
        if (complete) begin
          cmd.remove     = 1'b1;
          count_d        = count_q - 1'b1;
          res_d.status   = StComplete;
          res_d.run_time = rd.tm;
          res_d.time_left = '0;
          if (policy_q == PolRr || policy_q == PolPrioRr) rot_d = best_idx_q;
        end else begin
          cmd.upd_time    = 1'b1;
          cmd.wtime       = rd.tm - quantum_q;
          res_d.status    = StSlice;
          res_d.run_time  = quantum_q;
          res_d.time_left = rd.tm - quantum_q;
          if (policy_q == PolRr || policy_q == PolPrioRr) begin
            rot_d = (CW'(best_idx_q) + 1'b1 >= CW'(QUEUE_DEPTH)) ? '0 : best_idx_q + 1'b1;
          end
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        res_d.queue_count = 4'(count_q);
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegQuantum) ? 32'(quantum_q) : 32'(policy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rot_q       <= '0;
      policy_q    <= PolFifo;
      quantum_q   <= TimeW'(30);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rot_q   <= rot_d;
      if (cfg_wr) begin
        if (paddr[2] == RegPolicy) policy_q <= pwdata[2:0];
        else                       quantum_q <= pwdata[TimeW-1:0];
      end
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)              out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    best_idx_q  <= best_idx_d;
    best_time_q <= best_time_d;
    best_prio_q <= best_prio_d;
    best_wait_q <= best_wait_d;
    prod_q      <= prod_d;
    res_q       <= res_d;
    if (state_q == S_DONE && out_free) begin
      out_q             <= res_q;
      out_q.queue_count <= 4'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StFull |-> out_data_o.queue_count == 4'(QUEUE_DEPTH))
    else $error("queue full reported below depth");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StEmpty |-> out_data_o.queue_count == '0)
    else $error("empty dispatch with entries held");

  a_done_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StComplete |-> out_data_o.time_left == '0)
    else $error("completed run with time left");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("occupancy overflow");

endmodule

// ===== verif/sched_checker.sv =====
module sched_checker import mpsch_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  req_t        in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  rsp_t        out_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 8;

  logic [7:0]  q_id   [Depth];
  logic [3:0]  q_prio [Depth];
  logic [11:0] q_tm   [Depth];
  logic [15:0] q_wt   [Depth];
  int          q_len;
  int          rot;
  logic [2:0]  pol;
  logic [11:0] quant;
  rsp_t        expected_rsp_q[$];

  function automatic int lowest_time();
    int b;
    b = 0;
    for (int i = 1; i < q_len; i++) if (q_tm[i] < q_tm[b]) b = i;
    return b;
  endfunction

  function automatic int top_prio();
    int b;
    b = 0;
    for (int i = 1; i < q_len; i++) if (q_prio[i] > q_prio[b]) b = i;
    return b;
  endfunction

  function automatic rsp_t schedule(req_t r);
    rsp_t o;
    int   p;
    bit   pre;
    bit   rotating;
    logic [3:0] t;
    logic [63:0] lhs, rhs;
    o = '0;
    pre = 1;
    rotating = 0;
    if (r.req_type == ReqPush) begin
      if (q_len >= Depth) begin
        o.status = StFull;
      end else begin
        q_id[q_len] = r.proc_id;
        q_prio[q_len] = r.priority_req;
        q_tm[q_len] = r.burst_time;
        q_wt[q_len] = '0;
        q_len++;
        o.status = StPushed;
      end
    end else if (q_len == 0) begin
      o.status = StEmpty;
    end else begin
      p = 0;
      case (pol)
        PolFifo: pre = 0;
        PolSjf: begin p = lowest_time(); pre = 0; end
        PolPrio: begin p = top_prio(); pre = 0; end
        PolHrrn: begin
          pre = 0;
          for (int i = 0; i < q_len; i++) if (q_wt[i] != 16'hFFFF) q_wt[i]++;
          for (int i = 1; i < q_len; i++) begin
            lhs = 64'(q_wt[i]) * 64'(q_tm[p]);
            rhs = 64'(q_wt[p]) * 64'(q_tm[i]);
            if (lhs > rhs) p = i;
          end
        end
        PolRr: begin
          if (rot >= q_len) rot = 0;
          p = rot; rotating = 1;
        end
        PolPrioPre: p = top_prio();
        PolPrioRr: begin
          if (rot >= q_len) rot = 0;
          rotating = 1;
          t = q_prio[top_prio()];
          p = -1;
          for (int i = rot; i < q_len; i++) if (p < 0 && q_prio[i] == t) p = i;
          for (int i = 0; i < q_len; i++) if (p < 0 && q_prio[i] == t) p = i;
        end
        default: p = lowest_time();
      endcase
      o.run_id = q_id[p];
      if (!pre || q_tm[p] <= quant) begin
        o.run_time = q_tm[p];
        o.status = StComplete;
        for (int i = p + 1; i < q_len; i++) begin
          q_id[i-1] = q_id[i]; q_prio[i-1] = q_prio[i];
          q_tm[i-1] = q_tm[i]; q_wt[i-1] = q_wt[i];
        end
        q_len--;
        if (rotating) rot = p;
      end else begin
        q_tm[p] = q_tm[p] - quant;
        o.run_time = quant;
        o.time_left = q_tm[p];
        o.status = StSlice;
        if (rotating) rot = (p + 1 >= Depth) ? 0 : p + 1;
      end
    end
    o.queue_count = 4'(q_len);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      q_len = 0; rot = 0; pol = PolFifo; quant = 12'd30;
      expected_rsp_q.delete();
      fail_count_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i) begin
        if (paddr_i[2] == RegQuantum) quant = pwdata_i[11:0];
        else pol = pwdata_i[2:0];
      end
      if (in_valid_i && in_ready_i) expected_rsp_q.push_back(schedule(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result %p", out_data_i);
        end else begin
          e = expected_rsp_q.pop_front();
          if (e !== out_data_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: exp %p got %p", e, out_data_i);
          end
        end
      end
    end
    pending_o = expected_rsp_q.size();
  end

endmodule

// ===== verif/tb.sv =====
module tb import mpsch_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  req_t        in_data_i;
  rsp_t        out_data_o;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending;
  int          idle_cycles, sent, dispatches;
  bit          stall_on;
  bit          timed_out;

  multi_policy_ready_queue_scheduler_top dut (.*);

  sched_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 30);
  endfunction

  // receiver back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni || !stall_on) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 9) < 6) ? 1'b1 : ($urandom_range(0, 19) == 0 ? 1'b0 :
                        ($urandom_range(0, 1) == 1));
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(req_t r, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    // the block is never ready in the cycle after an accept, so the extra
    // wait before each transaction costs nothing
    repeat (g + 1) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
    in_valid_i <= 1'b0;
    sent++;
    if (r.req_type == ReqDispatch) dispatches++;
  endtask

  task automatic push(logic [7:0] id, logic [3:0] pr, logic [11:0] bt, bit gaps);
    req_t r;
    r.req_type = ReqPush; r.proc_id = id; r.priority_req = pr; r.burst_time = bt;
    send(r, gaps);
  endtask

  task automatic dispatch(bit gaps);
    req_t r;
    r = req_t'($bits(req_t)'($urandom()));
    r.req_type = ReqDispatch;
    send(r, gaps);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_mode(logic [2:0] p, logic [11:0] q);
    drain();
    reg_write({RegPolicy, 2'b00}, {29'd0, p});
    reg_write({RegQuantum, 2'b00}, {20'd0, q});
  endtask

  initial begin
    logic [11:0] qv;
    in_valid_i = 0; in_data_i = '0; psel = 0; penable = 0; pwrite = 0;
    paddr = '0; pwdata = '0; out_ready_i = 1; stall_on = 0;
    sent = 0; dispatches = 0; idle_cycles = 0;
    rst_ni = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty dispatch, fill past full, field extremes, zero burst
    dispatch(0);
    push(8'h00, 4'h0, 12'd0, 0);
    push(8'hFF, 4'hF, 12'hFFF, 0);
    push(8'hA5, 4'h5, 12'd1, 0);
    push(8'h5A, 4'hA, 12'hAAA, 0);
    push(8'h11, 4'hF, 12'h555, 0);
    push(8'h22, 4'h3, 12'd29, 0);
    push(8'h33, 4'h8, 12'd31, 0);
    push(8'h44, 4'h0, 12'd30, 0);
    push(8'h55, 4'h1, 12'd7, 0);
    for (int p = 0; p < 8; p++) begin
      set_mode(3'(p), (p == 4) ? 12'd0 : ((p == 6) ? 12'hFFF : 12'd1));
      dispatch(0);
    end
    set_mode(PolRr, 12'd30);
    repeat (8) dispatch(0);

    stall_on = 1;
    // random phases with varied policy and quantum
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: qv = 12'd1;
        1: qv = 12'hFFF;
        2: qv = 12'd0;
        default: qv = 12'($urandom_range(1, 300));
      endcase
      set_mode(3'(ph % 8), qv);
      for (int k = 0; k < 30; k++) begin
        if ($urandom_range(0, 1) == 1)
          push(8'($urandom()), 4'($urandom()),
               ($urandom_range(0, 9) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 400)),
               ph % 3 != 0);
        else
          dispatch(ph % 3 != 0);
      end
      if (ph == 5) drain();
    end

    drain();
    $display("Sent %0d requests (%0d dispatches) across all eight policies", sent, dispatches);
    $display("with quantum values including 0, 1 and 4095 and random back-pressure.");
    if (fail_count == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
